/* design/tiled_raster_bilinear_sampler_top_defines.svh */
// assertion macros for the tiled raster sampler
`ifndef TILED_RASTER_BILINEAR_SAMPLER_TOP_DEFINES_SVH
`define TILED_RASTER_BILINEAR_SAMPLER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TRBS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TRBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/trbs_pkg.sv */
package trbs_pkg;

    // divider widths
    localparam int DVN_W = 44;
    localparam int DVD_W = 33;
    localparam int CNT_W = 6;

    // shared multiplier operand width
    localparam int MUL_W = 34;

    // configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 41;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RASTER_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LON_ORIGIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_ORIGIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LON_STEP      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_STEP      = 3'd7;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_BEYOND  = 2'd2;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] init_rem;
        logic [DVN_W-1:0] dividend;
        logic [CNT_W-1:0] count;
        logic [DVD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVN_W-1:0] quot;
        logic [DVD_W-1:0] rem;
    } t_div_rsp;

endpackage

/* design/trbs_div.sv */
module trbs_div
    import trbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_rem;
    logic [DVN_W-1:0] r_dvn;
    logic [DVN_W-1:0] r_quot;
    logic [DVD_W-1:0] r_dsr;

    logic [DVD_W:0] trial;
    logic [DVD_W:0] diff;
    logic           ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvn[DVN_W-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = trial >= {1'b0, r_dsr};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.init_rem;
            r_dvn  <= i_req.dividend;
            r_quot <= '0;
            r_dsr  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DVD_W-1:0] : trial[DVD_W-1:0];
            r_dvn  <= {r_dvn[DVN_W-2:0], 1'b0};
            r_quot <= {r_quot[DVN_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

/* design/tiled_raster_bilinear_sampler_top.sv */
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready tdata: row, col, value, lon, lat; tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready tdata: elevation, status
// cfg       in   i_cfg_we                    i_cfg_idx, i_cfg_data
// a query runs a coordinate division of 44 steps and a weight division of 16 steps per axis
// on the bit-serial divider, then three tile index divisions of 13 and 12 steps, four corner
// passes and three interpolation steps; a query whose column or row weight clamps skips that
// weight division; a load runs only the tile index divisions and one corner pass, and a point
// outside the raster goes straight to the output
// one item at a time: s_axis_tready is high only while the sequencer is idle
// reset is synchronous and active low; it clears control and configuration, not the store
// a finished result waits in the output register until m_axis_tready; the sequencer
// holds in its output state while the previous result still waits
module tiled_raster_bilinear_sampler_top
    import trbs_pkg::*;
#(
    parameter int STORE_DEPTH      = 65536,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [11:0] pixel_row, [23:12] pixel_col, [55:24] pixel_value,
    // [96:56] query_lon, [137:97] query_lat, [143:138] zero
    input  logic [143:0]         s_axis_tdata,
    // [0] func
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [31:0] elevation, [33:32] status, [39:34] zero
    output logic [39:0]          m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_data
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int WF    = WEIGHT_FRAC_BITS;
    localparam int ADR_W = 48;
    localparam int XW    = 72;
    localparam int LIM_W = 46;

    typedef enum logic [22:0] {
        S_IDLE = 23'h000001,
        S_LIMC = 23'h000002,
        S_LIMR = 23'h000004,
        S_CHK  = 23'h000008,
        S_DIVC = 23'h000010,
        S_WC   = 23'h000020,
        S_DIVR = 23'h000040,
        S_WR   = 23'h000080,
        S_ACR  = 23'h000100,
        S_QR   = 23'h000200,
        S_QC   = 23'h000400,
        S_TSZ  = 23'h000800,
        S_TSZ2 = 23'h001000,
        S_M1   = 23'h002000,
        S_M2   = 23'h004000,
        S_M3   = 23'h008000,
        S_M4   = 23'h010000,
        S_M5   = 23'h020000,
        S_ACC  = 23'h040000,
        S_RD   = 23'h080000,
        S_LA   = 23'h100000,
        S_LB   = 23'h200000,
        S_OUT  = 23'h400000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [12:0] r_cfg_w, r_cfg_h;
    logic [10:0] r_cfg_tw, r_cfg_tl;
    logic signed [40:0] r_lon_org, r_lat_org;
    logic [32:0] r_lon_step, r_lat_step;

    // item registers
    logic               r_func;
    logic [11:0]        r_row, r_col;
    logic [31:0]        r_value;
    logic signed [41:0] r_dc, r_dr;
    logic               r_outc;
    logic [WF:0]        r_fc, r_fr;
    logic [12:0]        r_across;
    logic [11:0]        r_qr, r_qc;
    logic [9:0]         r_rr, r_rc;
    logic [20:0]        r_tsz;
    logic [24:0]        r_tile;
    logic [ADR_W-1:0]   r_acc, r_addr;
    logic [1:0]         r_k, r_li;
    logic signed [31:0] r_p [4];
    logic signed [2*MUL_W-1:0] r_prod;
    logic signed [31:0] r_res;
    logic [1:0]         r_stat;
    logic [31:0]        r_rdata;

    // output register
    logic               r_ovalid;
    logic [31:0]        r_oelev;
    logic [1:0]         r_ostat;

    // divider link
    t_div_req r_req, n_req;
    t_div_rsp div_rsp;

    trbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (div_rsp)
    );

    // store
    logic [31:0] mem [STORE_DEPTH];
    logic        wr_en;

    // clamped configuration
    logic [12:0] w_c, h_c;
    logic [10:0] tw_c, tl_c;
    logic [32:0] sc_c, sr_c;

    always_comb begin
        w_c  = (r_cfg_w < 13'd2) ? 13'd2 : ((r_cfg_w > 13'd4096) ? 13'd4096 : r_cfg_w);
        h_c  = (r_cfg_h < 13'd2) ? 13'd2 : ((r_cfg_h > 13'd4096) ? 13'd4096 : r_cfg_h);
        tw_c = (r_cfg_tw == 11'd0) ? 11'd1 : ((r_cfg_tw > 11'd1024) ? 11'd1024 : r_cfg_tw);
        tl_c = (r_cfg_tl == 11'd0) ? 11'd1 : ((r_cfg_tl > 11'd1024) ? 11'd1024 : r_cfg_tl);
        sc_c = (r_lon_step == 33'd0) ? 33'd1
             : ((r_lon_step > 33'h100000000) ? 33'h100000000 : r_lon_step);
        sr_c = (r_lat_step == 33'd0) ? 33'd1
             : ((r_lat_step > 33'h100000000) ? 33'h100000000 : r_lat_step);
    end

    // input field unpacking
    logic [11:0]        in_row, in_col;
    logic [31:0]        in_value;
    logic signed [40:0] in_lon, in_lat;
    logic               in_acc;

    assign in_row   = s_axis_tdata[11:0];
    assign in_col   = s_axis_tdata[23:12];
    assign in_value = s_axis_tdata[55:24];
    assign in_lon   = s_axis_tdata[96:56];
    assign in_lat   = s_axis_tdata[137:97];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    // corner selection: next row or column may cross into the next tile
    logic [11:0] qrk, qck;
    logic [9:0]  rrk, rck;

    always_comb begin
        qrk = r_qr;
        rrk = r_rr;
        if (r_k[1]) begin
            if (11'({1'b0, r_rr}) + 11'd1 == tl_c) begin
                qrk = r_qr + 12'd1;
                rrk = '0;
            end else begin
                rrk = r_rr + 10'd1;
            end
        end
        qck = r_qc;
        rck = r_rc;
        if (r_k[0]) begin
            if (11'({1'b0, r_rc}) + 11'd1 == tw_c) begin
                qck = r_qc + 12'd1;
                rck = '0;
            end else begin
                rck = r_rc + 10'd1;
            end
        end
    end

    // interpolation operands
    logic signed [31:0] la_a, la_b;
    logic [WF:0]        la_w;
    logic signed [32:0] la_diff;
    logic signed [XW-1:0] lerp_x;
    logic signed [31:0] lerp_res;

    always_comb begin
        case (r_li)
            2'd0: begin
                la_a = r_p[0]; la_b = r_p[1]; la_w = r_fc;
            end
            2'd1: begin
                la_a = r_p[2]; la_b = r_p[3]; la_w = r_fc;
            end
            default: begin
                la_a = r_p[0]; la_b = r_p[2]; la_w = r_fr;
            end
        endcase
        la_diff  = 33'(la_b) - 33'(la_a);
        lerp_x   = (XW'(la_a) <<< WF) + XW'(r_prod) + (XW'(1) <<< (WF - 1));
        lerp_res = lerp_x[WF+31:WF];
    end

    // shared multiplier operands
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic                    mul_en;

    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (r_state)
            S_LIMC: begin
                mul_a = MUL_W'(w_c - 13'd1); mul_b = MUL_W'(sc_c);
            end
            S_LIMR: begin
                mul_a = MUL_W'(h_c - 13'd1); mul_b = MUL_W'(sr_c);
            end
            S_TSZ: begin
                mul_a = MUL_W'(tw_c); mul_b = MUL_W'(tl_c);
            end
            S_M1: begin
                mul_a = MUL_W'(qrk); mul_b = MUL_W'(r_across);
            end
            S_M3: begin
                mul_a = MUL_W'(r_tile); mul_b = MUL_W'(r_tsz);
            end
            S_M4: begin
                mul_a = MUL_W'(rrk); mul_b = MUL_W'(tw_c);
            end
            S_LA: begin
                mul_a = MUL_W'(la_diff); mul_b = MUL_W'(la_w);
            end
            default: mul_en = 1'b0;
        endcase
    end

    // range checks
    logic outside, over;
    logic clamp_c, clamp_r;

    assign outside = r_dc[41] || r_dr[41] || r_outc
                  || ({5'b0, r_dr[40:0]} > r_prod[LIM_W-1:0]);
    assign over    = r_addr >= ADR_W'(STORE_DEPTH);
    assign clamp_c = div_rsp.quot > DVN_W'(w_c - 13'd2);
    assign clamp_r = div_rsp.quot > DVN_W'(h_c - 13'd2);
    assign wr_en   = (r_state == S_ACC) && !r_func && !over;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_req   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = s_axis_tuser ? S_LIMC : S_ACR;
                    if (!s_axis_tuser) begin
                        n_req.start    = 1'b1;
                        n_req.dividend = {13'(w_c + 13'(tw_c) - 13'd1), 31'b0};
                        n_req.count    = CNT_W'(13);
                        n_req.divisor  = DVD_W'(tw_c);
                    end
                end
            end
            S_LIMC: n_state = S_LIMR;
            S_LIMR: n_state = S_CHK;
            S_CHK: begin
                if (outside) begin
                    n_state = S_OUT;
                end else begin
                    n_state        = S_DIVC;
                    n_req.start    = 1'b1;
                    n_req.dividend = DVN_W'(r_dc[40:0]);
                    n_req.count    = CNT_W'(DVN_W);
                    n_req.divisor  = sc_c;
                end
            end
            S_DIVC: begin
                if (div_rsp.done) begin
                    n_req.start = 1'b1;
                    if (clamp_c) begin
                        n_state        = S_DIVR;
                        n_req.dividend = DVN_W'(r_dr[40:0]);
                        n_req.count    = CNT_W'(DVN_W);
                        n_req.divisor  = sr_c;
                    end else begin
                        n_state        = S_WC;
                        n_req.init_rem = div_rsp.rem;
                        n_req.count    = CNT_W'(WF);
                        n_req.divisor  = sc_c;
                    end
                end
            end
            S_WC: begin
                if (div_rsp.done) begin
                    n_state        = S_DIVR;
                    n_req.start    = 1'b1;
                    n_req.dividend = DVN_W'(r_dr[40:0]);
                    n_req.count    = CNT_W'(DVN_W);
                    n_req.divisor  = sr_c;
                end
            end
            S_DIVR: begin
                if (div_rsp.done) begin
                    n_req.start = 1'b1;
                    if (clamp_r) begin
                        n_state        = S_ACR;
                        n_req.dividend = {13'(w_c + 13'(tw_c) - 13'd1), 31'b0};
                        n_req.count    = CNT_W'(13);
                        n_req.divisor  = DVD_W'(tw_c);
                    end else begin
                        n_state        = S_WR;
                        n_req.init_rem = div_rsp.rem;
                        n_req.count    = CNT_W'(WF);
                        n_req.divisor  = sr_c;
                    end
                end
            end
            S_WR: begin
                if (div_rsp.done) begin
                    n_state        = S_ACR;
                    n_req.start    = 1'b1;
                    n_req.dividend = {13'(w_c + 13'(tw_c) - 13'd1), 31'b0};
                    n_req.count    = CNT_W'(13);
                    n_req.divisor  = DVD_W'(tw_c);
                end
            end
            S_ACR: begin
                if (div_rsp.done) begin
                    n_state        = S_QR;
                    n_req.start    = 1'b1;
                    n_req.dividend = {r_row, 32'b0};
                    n_req.count    = CNT_W'(12);
                    n_req.divisor  = DVD_W'(tl_c);
                end
            end
            S_QR: begin
                if (div_rsp.done) begin
                    n_state        = S_QC;
                    n_req.start    = 1'b1;
                    n_req.dividend = {r_col, 32'b0};
                    n_req.count    = CNT_W'(12);
                    n_req.divisor  = DVD_W'(tw_c);
                end
            end
            S_QC: begin
                if (div_rsp.done) n_state = S_TSZ;
            end
            S_TSZ:  n_state = S_TSZ2;
            S_TSZ2: n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = S_ACC;
            S_ACC:  n_state = (over || !r_func) ? S_OUT : S_RD;
            S_RD:   n_state = (r_k == 2'd3) ? S_LA : S_M1;
            S_LA:   n_state = S_LB;
            S_LB:   n_state = (r_li == 2'd2) ? S_OUT : S_LA;
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_req    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_req   <= n_req;
            if (r_state == S_OUT && (!r_ovalid || m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= 13'd256;
            r_cfg_h    <= 13'd256;
            r_cfg_tw   <= 11'd256;
            r_cfg_tl   <= 11'd256;
            r_lon_org  <= '0;
            r_lat_org  <= '0;
            r_lon_step <= 33'd1193046;
            r_lat_step <= 33'd1193046;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RASTER_WIDTH:  r_cfg_w    <= i_cfg_data[12:0];
                REG_RASTER_HEIGHT: r_cfg_h    <= i_cfg_data[12:0];
                REG_TILE_WIDTH:    r_cfg_tw   <= i_cfg_data[10:0];
                REG_TILE_LENGTH:   r_cfg_tl   <= i_cfg_data[10:0];
                REG_LON_ORIGIN:    r_lon_org  <= i_cfg_data[40:0];
                REG_LAT_ORIGIN:    r_lat_org  <= i_cfg_data[40:0];
                REG_LON_STEP:      r_lon_step <= i_cfg_data[32:0];
                REG_LAT_STEP:      r_lat_step <= i_cfg_data[32:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (mul_en) r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                r_func  <= s_axis_tuser;
                r_row   <= in_row;
                r_col   <= in_col;
                r_value <= in_value;
                r_dc    <= 42'(in_lon) - 42'(r_lon_org);
                r_dr    <= 42'(r_lat_org) - 42'(in_lat);
                r_res   <= '0;
                r_stat  <= ST_OK;
                r_k     <= '0;
                r_li    <= '0;
            end
            S_LIMR: r_outc <= {5'b0, r_dc[40:0]} > r_prod[LIM_W-1:0];
            S_CHK: begin
                if (outside) r_stat <= ST_OUTSIDE;
            end
            S_DIVC: begin
                if (div_rsp.done) begin
                    r_col <= clamp_c ? 12'(w_c - 13'd2) : div_rsp.quot[11:0];
                    if (clamp_c) r_fc <= (WF+1)'(1) << WF;
                end
            end
            S_WC: begin
                if (div_rsp.done) r_fc <= div_rsp.quot[WF:0];
            end
            S_DIVR: begin
                if (div_rsp.done) begin
                    r_row <= clamp_r ? 12'(h_c - 13'd2) : div_rsp.quot[11:0];
                    if (clamp_r) r_fr <= (WF+1)'(1) << WF;
                end
            end
            S_WR: begin
                if (div_rsp.done) r_fr <= div_rsp.quot[WF:0];
            end
            S_ACR: begin
                if (div_rsp.done) r_across <= div_rsp.quot[12:0];
            end
            S_QR: begin
                if (div_rsp.done) begin
                    r_qr <= div_rsp.quot[11:0];
                    r_rr <= div_rsp.rem[9:0];
                end
            end
            S_QC: begin
                if (div_rsp.done) begin
                    r_qc <= div_rsp.quot[11:0];
                    r_rc <= div_rsp.rem[9:0];
                end
            end
            S_TSZ2: r_tsz  <= r_prod[20:0];
            S_M2:   r_tile <= r_prod[24:0] + 25'(qck);
            S_M4:   r_acc  <= r_prod[ADR_W-1:0];
            S_M5:   r_addr <= r_acc + ADR_W'(r_prod[20:0]) + ADR_W'(rck);
            S_ACC: begin
                if (over) r_stat <= ST_BEYOND;
            end
            S_RD: begin
                r_p[r_k] <= r_rdata;
                r_k      <= r_k + 2'd1;
            end
            S_LB: begin
                case (r_li)
                    2'd0:    r_p[0] <= lerp_res;
                    2'd1:    r_p[2] <= lerp_res;
                    default: r_res  <= lerp_res;
                endcase
                r_li <= r_li + 2'd1;
            end
            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    r_oelev <= r_res;
                    r_ostat <= r_stat;
                end
            end
            default: ;
        endcase
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_addr[AW-1:0]] <= r_value;
        r_rdata <= mem[r_addr[AW-1:0]];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b0, r_ostat, r_oelev};

    `include "tiled_raster_bilinear_sampler_top_defines.svh"

    `TRBS_ASSERT_NOW(a_wr_in_store, wr_en, r_addr < ADR_W'(STORE_DEPTH), "store write out of range")
    `TRBS_ASSERT_NOW(a_err_zero, r_ovalid && (r_ostat != ST_OK), r_oelev == 32'd0, "error result not zero")
    `TRBS_ASSERT_NEXT(a_accept_path, in_acc, (r_state == S_LIMC) || (r_state == S_ACR), "bad start state")

endmodule

/* tb/tiled_raster_bilinear_sampler_top_test.sv */
`timescale 1ns / 1ps

// result checker with its own copy of the raster store and registers
class raster_scoreboard;
    localparam int DEPTH = 65536;
    localparam int WFB   = 16;

    logic [40:0] cfg [8];
    logic [31:0] pixels [int];
    logic [33:0] pending_results [$];   // {status, elevation}
    int errors;

    function new();
        cfg[0] = 256; cfg[1] = 256; cfg[2] = 256; cfg[3] = 256;
        cfg[4] = 0; cfg[5] = 0; cfg[6] = 1193046; cfg[7] = 1193046;
        errors = 0;
    endfunction

    function void note_config(int idx, logic [40:0] val);
        case (idx)
            0, 1: cfg[idx] = val[12:0];
            2, 3: cfg[idx] = val[10:0];
            4, 5: cfg[idx] = val;
            default: cfg[idx] = val[32:0];
        endcase
    endfunction

    // register as used by the block, clamped to its legal range
    function longint unsigned eff(int idx);
        longint unsigned v, lo, hi;
        v = cfg[idx];
        lo = (idx < 2) ? 2 : 1;
        hi = (idx < 2) ? 4096 : (idx < 4) ? 1024 : 64'h1_0000_0000;
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function longint unsigned tile_addr(longint unsigned row, longint unsigned col);
        longint unsigned tw, tl, across;
        tw = eff(2);
        tl = eff(3);
        across = (eff(0) + tw - 1) / tw;
        return ((row / tl) * across + col / tw) * tw * tl + (row % tl) * tw + (col % tw);
    endfunction

    // map a coordinate to the lower corner and weights; returns 1 when outside
    function bit map_point(logic [40:0] lon, logic [40:0] lat,
                           output longint unsigned c0, output longint unsigned r0,
                           output longint unsigned fc, output longint unsigned fr);
        longint dc, dr;
        longint unsigned sc, sr, w, h;
        w = eff(0); h = eff(1); sc = eff(6); sr = eff(7);
        dc = longint'($signed(lon)) - longint'($signed(cfg[4]));
        dr = longint'($signed(cfg[5])) - longint'($signed(lat));
        c0 = 0; r0 = 0; fc = 0; fr = 0;
        if (dc < 0 || dr < 0 || longint'(dc) > longint'((w - 1) * sc)
                || longint'(dr) > longint'((h - 1) * sr))
            return 1;
        c0 = longint'(dc) / sc;
        if (c0 > w - 2) c0 = w - 2;
        fc = ((dc - c0 * sc) << WFB) / sc;
        r0 = longint'(dr) / sr;
        if (r0 > h - 2) r0 = h - 2;
        fr = ((dr - r0 * sr) << WFB) / sr;
        return 0;
    endfunction

    // neighbors of a query that sit in the store but were never loaded
    function void unloaded_neighbors(logic [40:0] lon, logic [40:0] lat,
                                     ref logic [23:0] rc [$]);
        longint unsigned c0, r0, fc, fr, a;
        rc.delete();
        if (map_point(lon, lat, c0, r0, fc, fr)) return;
        for (int k = 0; k < 4; k++) begin
            a = tile_addr(r0 + k / 2, c0 + k % 2);
            if (a < DEPTH && !pixels.exists(int'(a)))
                rc.push_back({12'(c0 + k % 2), 12'(r0 + k / 2)});
        end
    endfunction

    // one interpolation step, rounded to nearest with ties up
    function longint blend(longint a, longint b, longint unsigned w);
        return (a * (longint'(1) <<< WFB) + (b - a) * longint'(w)
                + (longint'(1) <<< (WFB - 1))) >>> WFB;
    endfunction

    function void note_item(bit is_query, logic [143:0] d);
        longint unsigned c0, r0, fc, fr, a [4];
        longint p [4], top, bot;
        logic [1:0] st;
        logic [31:0] elev;
        st = trbs_pkg::ST_OK;
        elev = '0;
        if (!is_query) begin
            a[0] = tile_addr(d[11:0], d[23:12]);
            if (a[0] >= DEPTH) st = trbs_pkg::ST_BEYOND;
            else pixels[int'(a[0])] = d[55:24];
        end else if (map_point(d[96:56], d[137:97], c0, r0, fc, fr)) begin
            st = trbs_pkg::ST_OUTSIDE;
        end else begin
            for (int k = 0; k < 4; k++) begin
                a[k] = tile_addr(r0 + k / 2, c0 + k % 2);
                if (a[k] >= DEPTH) st = trbs_pkg::ST_BEYOND;
                else p[k] = longint'($signed(pixels[int'(a[k])]));
            end
            if (st == trbs_pkg::ST_OK) begin
                top = blend(p[0], p[1], fc);
                bot = blend(p[2], p[3], fc);
                elev = 32'(blend(top, bot, fr));
            end
        end
        pending_results.push_back({st, elev});
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check(logic [39:0] t);
        logic [33:0] e;
        if (pending_results.size() == 0) begin
            report($sformatf("unexpected result %h", t));
            return;
        end
        e = pending_results.pop_front();
        if (t[31:0] !== e[31:0])
            report($sformatf("elevation %h, want %h", t[31:0], e[31:0]));
        if (t[33:32] !== e[33:32])
            report($sformatf("status %0d, want %0d", t[33:32], e[33:32]));
    endtask
endclass

module tiled_raster_bilinear_sampler_top_test;
    import trbs_pkg::*;

    localparam bit FUNC_LOAD  = 1'b0;
    localparam bit FUNC_QUERY = 1'b1;
    localparam int RANDOM_ITEMS = 1750;
    localparam int STALL_LIMIT  = 20000;
    localparam int SETTLE       = 400;
    localparam longint COORD_MAX = 773094113280;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [143:0]   s_axis_tdata;
    logic           s_axis_tuser;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [39:0]    m_axis_tdata;
    logic           i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DW-1:0]    i_cfg_data;

    raster_scoreboard sb;
    int items_sent;
    int idle_mode;
    int quiet_cycles;

    tiled_raster_bilinear_sampler_top u_dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: check each item and stall at random
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
            m_axis_tready <= ($urandom_range(0, 99) >=
                              (idle_mode == 0 ? 71 : idle_mode == 1 ? 26 : 0));
        end
    end

    // watchdog on cycles with no item moving
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_item(bit is_query, logic [143:0] d);
        int pct;
        int gap;
        pct = (idle_mode == 0) ? 26 : (idle_mode == 1) ? 71 : 0;
        gap = 0;
        while ($urandom_range(0, 99) < pct && gap < 40) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= is_query;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(is_query, d);
        items_sent++;
        idle_mode = (items_sent * 3) / (RANDOM_ITEMS + 200);
        if (idle_mode > 2) idle_mode = 2;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_load(logic [11:0] row, logic [11:0] col, logic [31:0] val);
        send_item(FUNC_LOAD, {6'b0, 41'({$urandom, $urandom}), 41'({$urandom, $urandom}),
                              val, col, row});
    endtask

    // pick an offset along one axis: inside, on the grid, at the far edge or outside
    function automatic longint pick_offset(int kind, longint unsigned size,
                                           longint unsigned step);
        longint unsigned span, frac;
        span = (size - 1) * step;
        case (kind)
            0: return -longint'($urandom_range(1, 1000));
            1: return span + $urandom_range(1, 1000);
            2: return span;
            3: return 0;
            4: return $urandom_range(0, size - 1) * step;
            default: begin
                frac = (longint'($urandom) * step) >> 32;
                if ($urandom_range(0, size - 1) * step + frac > span) return span;
                return $urandom_range(0, size - 1) * step + frac;
            end
        endcase
    endfunction

    // a query with its missing neighbors loaded first
    task automatic send_query(int ckind, int rkind);
        logic [40:0] lon, lat;
        logic [23:0] rc [$];
        if (ckind < 0) lon = 41'({$urandom, $urandom});
        else lon = 41'(longint'($signed(sb.cfg[4])) + pick_offset(ckind, sb.eff(0), sb.eff(6)));
        if (rkind < 0) lat = 41'({$urandom, $urandom});
        else lat = 41'(longint'($signed(sb.cfg[5])) - pick_offset(rkind, sb.eff(1), sb.eff(7)));
        sb.unloaded_neighbors(lon, lat, rc);
        foreach (rc[k]) send_load(rc[k][11:0], rc[k][23:12], rand_value());
        send_item(FUNC_QUERY, {6'b0, lat, lon, 32'($urandom), 24'($urandom)});
    endtask

    // stop sending and wait until every expected result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_config(logic [40:0] vals [8]);
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.note_config(i, vals[i]);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_items();
        send_load(12'd0, 12'd0, 32'h8000_0000);
        send_load(12'd0, 12'd1, 32'h7FFF_FFFF);
        send_load(12'd1, 12'd0, 32'h7FFF_FFFF);
        send_load(12'd1, 12'd1, 32'h8000_0000);
        send_load(12'hFFF, 12'hFFF, 32'h1234_5678);
        send_load(12'd0, 12'hFFF, 32'hFFFF_FFFF);
        send_load(12'd255, 12'd255, 32'h0000_0001);
        send_query(3, 3);
        send_query(5, 5);
        send_query(2, 2);
        send_query(2, 3);
        send_query(0, 5);
        send_query(1, 5);
        send_query(5, 0);
        send_query(5, 1);
        send_query(-1, -1);
        send_query(4, 4);
        send_query(3, 2);
    endtask

    initial begin
        logic [40:0] settings [6][8];
        sb = new();
        items_sent = 0;
        idle_mode = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        // width, height, tile width, tile length, origins, steps
        settings[0] = '{256, 256, 256, 256, 0, 0, 1193046, 1193046};
        settings[1] = '{2, 2, 1, 1, -COORD_MAX, COORD_MAX, 1, 1};
        settings[2] = '{4096, 4096, 1024, 1024, -500000000000, COORD_MAX,
                        41'h1000_0000, 41'h1_FFFF_FFFF};
        settings[3] = '{100, 37, 0, 2047, -212000000000, 5000, 41'h1_0000_0000, 3000};
        settings[4] = '{8191, 0, 16, 8, 123456789, -987654321, 0, 77777};
        settings[5] = '{300, 200, 64, 32, 41'h1FF_0000_0000, 999999999, 1193046, 999999};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_drained();
                write_config(settings[p]);
            end
            if (p == 0) directed_items();
            while (items_sent < ((p + 1) * RANDOM_ITEMS) / 6) begin
                if ($urandom_range(0, 9) < 3) begin
                    if ($urandom_range(0, 3) == 0)
                        send_load(12'($urandom), 12'($urandom), rand_value());
                    else
                        send_load(12'($urandom_range(0, sb.eff(1) - 1)),
                                  12'($urandom_range(0, sb.eff(0) - 1)), rand_value());
                end else if ($urandom_range(0, 19) == 0) begin
                    send_query(-1, -1);
                end else begin
                    send_query($urandom_range(0, 15), $urandom_range(0, 15));
                end
            end
        end
        wait_drained();
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

/* sim.f */
+incdir+design
design/trbs_pkg.sv
design/trbs_div.sv
design/tiled_raster_bilinear_sampler_top.sv
tb/tiled_raster_bilinear_sampler_top_test.sv
